// ----- rtl/hcr_pkg.sv -----
// shared constants, color stops and the controller command bundle
// for the height to color ramp; no dependencies
package hcr_pkg;

    localparam int HEIGHT_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int Z_BITS     = 32;
    localparam int COLOR_BITS = 24;
    localparam int CHAN_BITS  = 8;
    localparam int NUM_CHANS  = 3;

    localparam logic [COLOR_BITS-1:0] STOP_WHITE = 24'hFFFFFF;
    localparam logic [COLOR_BITS-1:0] STOP_BROWN = 24'h8B4513;
    localparam logic [COLOR_BITS-1:0] STOP_GREEN = 24'h228B22;

    typedef struct packed {
        logic take_item;
        logic do_mid;
        logic do_seg;
        logic do_div;
        logic do_out;
    } hcr_cmd_t;

endpackage

// ----- rtl/hcr_ctrl.sv -----
// controller for the height to color ramp: sequences middle, segment,
// divider steps and output load; depends on hcr_pkg
module hcr_ctrl #(
    parameter int FRAC_BITS = hcr_pkg::FRAC_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_op,
    output logic             s_ready,
    input  logic             m_ready,
    output logic             m_valid,
    output hcr_pkg::hcr_cmd_t cmd
);

    localparam int CW = $clog2(FRAC_BITS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MID  = 3'd1;
    localparam logic [2:0] ST_SEG  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          m_valid_reg, m_valid_next;
    logic          out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        cmd.take_item = s_valid && s_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_op) begin
                    state_next = ST_MID;
                end
            end
            ST_MID: begin
                cmd.do_mid = 1'b1;
                state_next = ST_SEG;
            end
            ST_SEG: begin
                cmd.do_seg = 1'b1;
                cnt_next   = CW'(FRAC_BITS - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.do_div = 1'b1;
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.do_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.do_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- rtl/hcr_dp.sv -----
// datapath for the height to color ramp: min and max tracking, middle
// height, segment select, radix-2 divider and channel blend; depends on hcr_pkg
module hcr_dp #(
    parameter int HEIGHT_BITS = hcr_pkg::HEIGHT_BITS_DEF,
    parameter int FRAC_BITS   = hcr_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  hcr_pkg::hcr_cmd_t                cmd,
    input  logic                             s_op,
    input  logic                             s_first,
    input  logic signed [hcr_pkg::Z_BITS-1:0] s_z,
    output logic [hcr_pkg::COLOR_BITS-1:0]   m_color
);

    localparam int W  = HEIGHT_BITS + 2;
    localparam int RB = FRAC_BITS + 1;
    localparam int PB = RB + hcr_pkg::CHAN_BITS + 1;

    logic signed [HEIGHT_BITS-1:0] z_in;
    logic signed [HEIGHT_BITS-1:0] low_reg, low_next;
    logic signed [HEIGHT_BITS-1:0] high_reg, high_next;
    logic signed [HEIGHT_BITS-1:0] z_reg;

    logic signed [W-1:0] sum_w, mid_w, lo_w, hi_w;
    logic signed [W-1:0] mid_reg, lo_adj_reg, hi_adj_reg;

    logic signed [W-1:0] z_w, num_w, den_w;
    logic                lower_w;
    logic                upper_reg, zero_reg, one_reg;
    logic [W-1:0]        rem_reg, den_reg, rem2, rem_next;
    logic                ge;
    logic [FRAC_BITS-1:0] q_reg;

    logic [RB-1:0] ratio, inv_ratio;
    logic [hcr_pkg::COLOR_BITS-1:0] stop_a, stop_b, color_next, color_reg;

    assign z_in = s_z[HEIGHT_BITS-1:0];

    // running minimum and maximum
    always_comb begin
        low_next  = low_reg;
        high_next = high_reg;
        if (cmd.take_item && !s_op) begin
            if (s_first) begin
                low_next  = z_in;
                high_next = z_in;
            end else begin
                if (z_in < low_reg) begin
                    low_next = z_in;
                end
                if (z_in > high_reg) begin
                    high_next = z_in;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= {1'b0, {(HEIGHT_BITS-1){1'b1}}};
            high_reg <= {1'b1, {(HEIGHT_BITS-1){1'b0}}};
        end else begin
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    // middle height, truncated toward zero, and endpoint nudge
    always_comb begin
        sum_w = W'(low_reg) + W'(high_reg);
        mid_w = $signed(sum_w + W'(sum_w[W-1] & sum_w[0])) >>> 1;
        lo_w  = W'(low_reg) - W'(W'(low_reg) == mid_w);
        hi_w  = W'(high_reg) + W'(W'(high_reg) == mid_w);
    end

    // segment select: numerator and denominator of the ratio within the selected segment
    always_comb begin
        z_w     = W'(z_reg);
        lower_w = z_w < mid_reg;
        if (lower_w) begin
            num_w = z_w - lo_adj_reg;
            den_w = mid_reg - lo_adj_reg;
        end else begin
            num_w = z_w - mid_reg;
            den_w = hi_adj_reg - mid_reg;
        end
    end

    // restoring divider, one quotient bit per step
    always_comb begin
        rem2     = {rem_reg[W-2:0], 1'b0};
        ge       = rem2 >= den_reg;
        rem_next = ge ? rem2 - den_reg : rem2;
    end

    // blend between the two stops of the selected segment
    always_comb begin
        logic [PB-1:0] acc;
        if (one_reg) begin
            ratio = {1'b1, {FRAC_BITS{1'b0}}};
        end else if (zero_reg) begin
            ratio = '0;
        end else begin
            ratio = {1'b0, q_reg};
        end
        inv_ratio  = {1'b1, {FRAC_BITS{1'b0}}} - ratio;
        stop_a     = upper_reg ? hcr_pkg::STOP_BROWN : hcr_pkg::STOP_WHITE;
        stop_b     = upper_reg ? hcr_pkg::STOP_GREEN : hcr_pkg::STOP_BROWN;
        color_next = '0;
        for (int c = 0; c < hcr_pkg::NUM_CHANS; c++) begin
            acc = PB'(ratio) * PB'(stop_b[c*hcr_pkg::CHAN_BITS +: hcr_pkg::CHAN_BITS])
                + PB'(inv_ratio) * PB'(stop_a[c*hcr_pkg::CHAN_BITS +: hcr_pkg::CHAN_BITS]);
            color_next[c*hcr_pkg::CHAN_BITS +: hcr_pkg::CHAN_BITS] =
                acc[FRAC_BITS +: hcr_pkg::CHAN_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_item && s_op) begin
            z_reg <= z_in;
        end
        if (cmd.do_mid) begin
            mid_reg    <= mid_w;
            lo_adj_reg <= lo_w;
            hi_adj_reg <= hi_w;
        end
        if (cmd.do_seg) begin
            upper_reg <= !lower_w;
            zero_reg  <= num_w <= 0;
            one_reg   <= (num_w > 0) && (num_w >= den_w);
            rem_reg   <= num_w;
            den_reg   <= den_w;
        end
        if (cmd.do_div) begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[FRAC_BITS-2:0], ge};
        end
        if (cmd.do_out) begin
            color_reg <= color_next;
        end
    end

    assign m_color = color_reg;

endmodule

// ----- rtl/height_to_color_ramp_top.sv -----
// top level of the height to color ramp: controller plus datapath
// depends on hcr_pkg, hcr_ctrl and hcr_dp
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------
//  input    | s_valid / s_ready   | s_op, s_first, s_z[31:0]
//  result   | m_valid / m_ready   | m_color[23:0]
//
// a scan item (op 0) is taken and ready stays high
// a color item steps through the middle, segment, divider and output states;
// the one-bit-per-cycle divider forms the ratio
// the result sits in an output register; the next item is taken while it waits
// reset is synchronous active low; min and max restart at the extreme heights
module height_to_color_ramp_top #(
    parameter int HEIGHT_BITS = hcr_pkg::HEIGHT_BITS_DEF,
    parameter int FRAC_BITS   = hcr_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic                              s_first,
    input  logic signed [hcr_pkg::Z_BITS-1:0] s_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [hcr_pkg::COLOR_BITS-1:0]    m_color
);

    hcr_pkg::hcr_cmd_t cmd;

    hcr_ctrl #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .cmd     (cmd)
    );

    hcr_dp #(
        .HEIGHT_BITS(HEIGHT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_op    (s_op),
        .s_first (s_first),
        .s_z     (s_z),
        .m_color (m_color)
    );

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_out |-> (!m_valid || m_ready))
        else $error("output register overwritten");

    a_color_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op) |=> !s_ready)
        else $error("color item did not make block busy");

    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_out |=> m_valid)
        else $error("loaded result not shown");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.do_mid, cmd.do_seg, cmd.do_div, cmd.do_out, cmd.take_item}))
        else $error("overlapping commands");

endmodule
